@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

	// Capacity of the queue and width of a stored identifier.
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;

	// Width of the fill count, which must be able to hold QUEUE_DEPTH itself.
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Fixed widths of the port fields.
	localparam int PORT_ID_W  = 16;
	localparam int PRI_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 5;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_ENQ  = 2'd1,
		CMD_DEQ  = 2'd2
	} cmd_kind_t;

	// Contents of one slot of the queue.
	typedef struct packed {
		logic               valid;
		logic [ID_BITS-1:0] id;
		logic [PRI_W-1:0]   pri;
	} slot_t;

	// Command broadcast to every cell in a cycle.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [ID_BITS-1:0] id;
		logic [PRI_W-1:0]   pri;
	} cell_cmd_t;

endpackage

@@ design/stable_priority_queue_unit.sv @@
`timescale 1ns / 1ps

// Stable sorted priority queue built as a row of slot cells.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   in       in_valid / in_ready    operation, entry_id, entry_priority
//   out      out_valid / out_ready  status, out_id, out_priority, occupancy
//
// All slots compare against the arriving
// priority in parallel and shift by at most one place, so a new transaction
// can be accepted on every clock edge while the output is not stalled.
// Each input transaction yields one result in the cycle after it is accepted, held in an output
// register; the input is ready whenever that register is empty or being read.
// Reset empties the queue at once; no clearing pass is needed.
// A stalled output holds the input off; nothing is dropped or repeated.
module stable_priority_queue_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   operation,
	input  logic [spq_pkg::PORT_ID_W-1:0]          entry_id,
	input  logic [spq_pkg::PRI_W-1:0]              entry_priority,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [spq_pkg::STATUS_W-1:0]           status,
	output logic [spq_pkg::PORT_ID_W-1:0]          out_id,
	output logic [spq_pkg::PRI_W-1:0]              out_priority,
	output logic [spq_pkg::OCC_W-1:0]              occupancy
);

	localparam int N = spq_pkg::QUEUE_DEPTH;

	spq_pkg::slot_t     cell_slot  [N];
	logic               cell_cmp   [N];
	spq_pkg::slot_t     left_slot  [N];
	logic               left_cmp   [N];
	spq_pkg::slot_t     right_slot [N];
	spq_pkg::cell_cmd_t cmd;

	logic [N-1:0]       valid_vec;
	logic               in_accept;
	logic               full;
	logic               empty;
	logic               enq_ok;
	logic               deq_ok;
	logic [spq_pkg::PRI_W-1:0] new_pri;
	logic [spq_pkg::ID_BITS+spq_pkg::PORT_ID_W-1:0] id_in_wide;
	logic [spq_pkg::ID_BITS+spq_pkg::PORT_ID_W-1:0] id_out_wide;
	logic [spq_pkg::CNT_W+spq_pkg::OCC_W-1:0]       occ_wide;

	logic [spq_pkg::CNT_W-1:0]     count_q;
	logic [spq_pkg::CNT_W-1:0]     count_d;
	logic                          out_valid_q;
	spq_pkg::status_t              status_q;
	logic [spq_pkg::PORT_ID_W-1:0] out_id_q;
	logic [spq_pkg::PRI_W-1:0]     out_priority_q;
	logic [spq_pkg::OCC_W-1:0]     occupancy_q;

	// The output register parts the two sides: a new transaction enters when
	// the pending result is absent or is being taken in this cycle.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	// The valid slots always form a prefix, so the ends of the row tell
	// whether the queue is full or empty.
	assign full  = cell_slot[N-1].valid;
	assign empty = !cell_slot[0].valid;

	assign enq_ok = in_accept && (operation == spq_pkg::OP_ENQ) && !full;
	assign deq_ok = in_accept && (operation == spq_pkg::OP_DEQ) && !empty;

	// A priority of zero is treated as the most urgent level.
	assign new_pri = (entry_priority == '0) ? spq_pkg::PRI_W'(1) : entry_priority;

	// Identifiers are kept at the stored width and read back at the port width.
	assign id_in_wide  = {{spq_pkg::ID_BITS{1'b0}}, entry_id};
	assign id_out_wide = {{spq_pkg::PORT_ID_W{1'b0}}, cell_slot[0].id};

	always_comb begin
		cmd.id  = id_in_wide[spq_pkg::ID_BITS-1:0];
		cmd.pri = new_pri;
		if (enq_ok) begin
			cmd.kind = spq_pkg::CMD_ENQ;
		end else if (deq_ok) begin
			cmd.kind = spq_pkg::CMD_DEQ;
		end else begin
			cmd.kind = spq_pkg::CMD_HOLD;
		end
	end

	// The row of cells. The front cell sees an empty, non-comparing neighbour
	// on its left, so it takes the new entry whenever it is at the insertion
	// point; the back cell pulls in an empty slot on a removal.
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_front
			always_comb begin
				left_slot[i] = '0;
				left_cmp[i]  = 1'b0;
			end
		end else begin : g_inner
			always_comb begin
				left_slot[i] = cell_slot[i-1];
				left_cmp[i]  = cell_cmp[i-1];
			end
		end
		if (i == N - 1) begin : g_back
			assign right_slot[i] = '0;
		end else begin : g_mid
			assign right_slot[i] = cell_slot[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_slot  (left_slot[i]),
			.left_cmp   (left_cmp[i]),
			.right_slot (right_slot[i]),
			.slot_q     (cell_slot[i]),
			.cmp        (cell_cmp[i])
		);

		assign valid_vec[i] = cell_slot[i].valid;
	end

	// Fill count, kept alongside the row so the result can carry it at once.
	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + spq_pkg::CNT_W'(1);
		end else if (deq_ok) begin
			count_d = count_q - spq_pkg::CNT_W'(1);
		end
	end

	assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; it is loaded only when a transaction is accepted, so a
	// stalled result holds its value.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			occupancy_q <= occ_wide[spq_pkg::OCC_W-1:0];
			if (operation == spq_pkg::OP_DEQ) begin
				if (empty) begin
					status_q       <= spq_pkg::ST_EMPTY;
					out_id_q       <= '0;
					out_priority_q <= '0;
				end else begin
					status_q       <= spq_pkg::ST_OK;
					out_id_q       <= id_out_wide[spq_pkg::PORT_ID_W-1:0];
					out_priority_q <= cell_slot[0].pri;
				end
			end else begin
				status_q       <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
				out_id_q       <= '0;
				out_priority_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_priority_q;
	assign occupancy    = occupancy_q;

	// The valid slots must always form an unbroken run from the front.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + N'(1)) & valid_vec) == '0)
		else $error("queue slots are not a contiguous prefix");

	// The fill count must agree with the number of occupied cells.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == spq_pkg::CNT_W'($countones(valid_vec)))
		else $error("fill count disagrees with occupied cells");

	// A successful removal returns an entry with a real priority level.
	a_deq_priority: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |=> (out_valid && status == spq_pkg::ST_OK && out_priority != '0))
		else $error("removal returned an entry without a priority");

	// A refused insertion leaves the row untouched.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && operation == spq_pkg::OP_ENQ && full) |=> $stable(valid_vec))
		else $error("insertion into a full queue changed its contents");

endmodule

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted queue. On an insertion a slot at or behind the
// insertion point either takes the new entry or its left neighbour's contents;
// on a removal every slot takes its right neighbour's contents.
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  spq_pkg::slot_t     left_slot,
	input  logic               left_cmp,
	input  spq_pkg::slot_t     right_slot,
	output spq_pkg::slot_t     slot_q,
	output logic               cmp
);

	spq_pkg::slot_t                  slot_d;
	logic                            valid_q;
	logic [spq_pkg::ID_BITS-1:0]     id_q;
	logic [spq_pkg::PRI_W-1:0]       pri_q;

	// The slot is presented as one structure built from its three registers.
	always_comb begin
		slot_q.valid = valid_q;
		slot_q.id    = id_q;
		slot_q.pri   = pri_q;
	end

	// True when this slot lies at or behind the insertion point: it is empty,
	// or it holds a strictly less urgent entry than the one arriving.
	assign cmp = !slot_q.valid || (slot_q.pri > cmd.pri);

	always_comb begin
		slot_d = slot_q;
		case (cmd.kind)
			spq_pkg::CMD_ENQ: begin
				if (cmp) begin
					if (left_cmp) begin
						slot_d = left_slot;
					end else begin
						slot_d.valid = 1'b1;
						slot_d.id    = cmd.id;
						slot_d.pri   = cmd.pri;
					end
				end
			end
			spq_pkg::CMD_DEQ: begin
				slot_d = right_slot;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= slot_d.id;
		pri_q <= slot_d.pri;
	end

endmodule

@@ dv/tb_stable_priority_queue_unit.sv @@
`timescale 1ns / 1ps

// Tracks the entries the queue should hold and the results it still owes.
class spq_checker;

	typedef struct {
		logic [spq_pkg::ID_BITS-1:0] id;
		logic [spq_pkg::PRI_W-1:0]   pri;
	} held_entry_t;

	typedef struct {
		spq_pkg::status_t              status;
		logic [spq_pkg::PORT_ID_W-1:0] id;
		logic [spq_pkg::PRI_W-1:0]     pri;
		logic [spq_pkg::OCC_W-1:0]     occ;
	} owed_result_t;

	held_entry_t  held[$];
	owed_result_t awaited[$];
	int           mismatches;

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endfunction

	// Works out the result of one accepted request and updates the held entries.
	function void note_request(spq_pkg::op_t op, logic [spq_pkg::PORT_ID_W-1:0] id,
			logic [spq_pkg::PRI_W-1:0] pri);
		owed_result_t r;
		held_entry_t  e;
		int           pos;
		r.status = spq_pkg::ST_OK;
		r.id     = '0;
		r.pri    = '0;
		e.id     = id;
		e.pri    = (pri == 2'd0) ? 2'd1 : pri;
		if (op == spq_pkg::OP_ENQ) begin
			if (held.size() >= spq_pkg::QUEUE_DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				pos = held.size();
				for (int i = 0; i < held.size(); i++) begin
					if (held[i].pri > e.pri) begin
						pos = i;
						break;
					end
				end
				held.insert(pos, e);
			end
		end else begin
			if (held.size() == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				e     = held.pop_front();
				r.id  = e.id;
				r.pri = e.pri;
			end
		end
		r.occ = spq_pkg::OCC_W'(held.size());
		awaited.push_back(r);
	endfunction

	function void check_result(logic [spq_pkg::STATUS_W-1:0] status,
			logic [spq_pkg::PORT_ID_W-1:0] id, logic [spq_pkg::PRI_W-1:0] pri,
			logic [spq_pkg::OCC_W-1:0] occ);
		owed_result_t r;
		if (awaited.size() == 0) begin
			flag($sformatf("result with nothing owed: status %0d id %h pri %0d occ %0d",
				status, id, pri, occ));
			return;
		end
		r = awaited.pop_front();
		if (status !== r.status || id !== r.id || pri !== r.pri || occ !== r.occ)
			flag($sformatf("expected status %0d id %h pri %0d occ %0d, got %0d %h %0d %0d",
				r.status, r.id, r.pri, r.occ, status, id, pri, occ));
	endfunction

endclass

module tb_stable_priority_queue_unit;

	// Generous bound: even if every transaction waited out the longest sender gap
	// and the longest receiver stall, the run would finish well inside this.
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 950;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          operation = 1'b0;
	logic [spq_pkg::PORT_ID_W-1:0] entry_id = '0;
	logic [spq_pkg::PRI_W-1:0]     entry_priority = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [spq_pkg::STATUS_W-1:0]  status;
	logic [spq_pkg::PORT_ID_W-1:0] out_id;
	logic [spq_pkg::PRI_W-1:0]     out_priority;
	logic [spq_pkg::OCC_W-1:0]     occupancy;

	spq_checker  tracker = new();
	int unsigned cycle_count = 0;
	bit          long_hold_req = 1'b0;
	bit          tx_quiet = 1'b0;

	always #4 clk = ~clk;

	stable_priority_queue_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.entry_id       (entry_id),
		.entry_priority (entry_priority),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_id         (out_id),
		.out_priority   (out_priority),
		.occupancy      (occupancy)
	);

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request from the falling edge and holds it until the queue takes it.
	// The valid line is not lowered here, so back-to-back transactions keep it high.
	task automatic offer(input spq_pkg::op_t op, input logic [spq_pkg::PORT_ID_W-1:0] id,
			input logic [spq_pkg::PRI_W-1:0] pri);
		@(negedge clk);
		in_valid       <= 1'b1;
		operation      <= op;
		entry_id       <= id;
		entry_priority <= pri;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_request(op, id, pri);
	endtask

	task automatic rest(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Watchdog: a hung handshake must not leave the run spinning for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Every result transaction is checked against the oldest owed result, sampled at
	// the rising edge before the block updates its registers.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(status, out_id, out_priority, occupancy);
	end

	// The receiver alternates between bursts of readiness and gaps of random length.
	// When asked, it holds off for a long stretch of its own counting, so that the
	// output register fills and the block stops taking requests.
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				repeat (120) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				run = $urandom_range(1, 20);
				if ($urandom_range(0, 7) == 0)
					run = $urandom_range(50, 200);
				repeat (run) begin
					@(negedge clk);
					out_ready <= 1'b1;
				end
				run = pick_gap();
				repeat (run) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int enq_pct;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A dequeue on the empty queue comes first, with junk in the
		// ignored fields.
		offer(spq_pkg::OP_DEQ, 16'hFFFF, 2'd3);
		// A priority of zero must be stored as the most urgent level.
		offer(spq_pkg::OP_ENQ, 16'h0000, 2'd0);
		offer(spq_pkg::OP_ENQ, 16'hFFFF, 2'd3);
		offer(spq_pkg::OP_ENQ, 16'h5A5A, 2'd2);
		// Same level as the saturated entry, so it must queue up behind it.
		offer(spq_pkg::OP_ENQ, 16'hA5A5, 2'd1);
		// Fill the remaining slots, mixing the levels.
		for (int i = 0; i < spq_pkg::QUEUE_DEPTH - 4; i++)
			offer(spq_pkg::OP_ENQ, 16'h0100 + 16'(i), 2'(1 + i % 3));
		// The queue is now full, so this one is refused.
		offer(spq_pkg::OP_ENQ, 16'hBEEF, 2'd1);
		repeat (5)
			offer(spq_pkg::OP_DEQ, 16'h0000, 2'd0);

		// Random part, in phases that lean towards filling, draining or neither, so
		// the queue keeps swinging between empty and full.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						enq_pct = 20;
					end
					1: begin
						enq_pct = 50;
					end
					default: begin
						enq_pct = 80;
					end
				endcase
				tx_quiet = ($urandom_range(0, 3) == 0);
			end
			// Long receiver hold-off while requests keep coming.
			if (n == 300)
				long_hold_req = 1'b1;
			// Pause the sender until every owed result has been delivered.
			if (n == 600) begin
				rest(1);
				while (tracker.awaited.size() != 0)
					@(posedge clk);
			end
			offer(($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
				16'($urandom), 2'($urandom_range(0, 3)));
			if (!tx_quiet)
				rest(pick_gap());
		end
		rest(1);

		while (tracker.awaited.size() != 0)
			@(posedge clk);
		// The spare cycles below catch any stray result.
		repeat (10) @(posedge clk);

		if (tracker.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ stable_priority_queue_unit.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_unit.sv
dv/tb_stable_priority_queue_unit.sv
